// File: src/ccs_pkg.sv
// Shared types and constants for the calorimeter cluster sum block.
package ccs_pkg;

    localparam int unsigned SUM_W = 29;
    localparam int unsigned E_W   = 24;
    localparam int unsigned P_W   = 16;
    localparam int unsigned ACC_W = 36;   // sum width before saturation
    localparam int unsigned WP_W  = 48;   // position times energy accumulator
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic [2:0]          col;
        logic [2:0]          row;
        logic signed [E_W-1:0] energy;
        logic signed [P_W-1:0] pos_x;
        logic signed [P_W-1:0] pos_y;
    } t_hit;

    typedef struct packed {
        logic                   good;
        logic [SUM_W-1:0]       sum_center;
        logic [SUM_W-1:0]       sum_cross;
        logic [SUM_W-1:0]       sum_three;
        logic [SUM_W-1:0]       sum_five;
        logic [SUM_W-1:0]       sum_total;
        logic signed [P_W-1:0]  centroid_x;
        logic signed [P_W-1:0]  centroid_y;
        logic [1:0]             ring_index;
        logic [2:0]             occupied_cross;
        logic [3:0]             occupied_three;
        logic [4:0]             occupied_five;
    } t_result;

    typedef struct packed {
        logic [2:0]          col;
        logic [2:0]          row;
        logic signed [E_W-1:0] energy;
        logic signed [P_W-1:0] pos_x;
        logic signed [P_W-1:0] pos_y;
        logic                last_hit;
    } t_in;

    // Start and operands of a signed rounded division.
    typedef struct packed {
        logic                     start;
        logic signed [WP_W-1:0]   num;
        logic [ACC_W-1:0]         den;
    } t_div_req;

    function automatic logic [SUM_W-1:0] sat29(input logic [ACC_W-1:0] v);
        return (v > ACC_W'(SUM_MAX)) ? SUM_MAX : v[SUM_W-1:0];
    endfunction

endpackage

// File: src/ccs_if.sv
// Valid/ready channel interface carrying one payload.
interface ccs_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/ccs_div.sv
// Iterative signed rounded divider with 16-bit clamping, one quotient bit a cycle.
module ccs_div
    import ccs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_div_req               i_req,
    output logic                   o_done,
    output logic signed [P_W-1:0]  o_quot
);
    localparam int unsigned N_W = WP_W + 1;   // magnitude of 2*|num|+den
    localparam int unsigned Q_W = 18;         // enough quotient bits to detect clamp
    localparam int unsigned D_W = ACC_W + 2;

    logic [N_W+1:0]   r_rem;
    logic [N_W+1:0]   r_num;
    logic [D_W-1:0]   r_den;
    logic [Q_W-1:0]   r_q;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [N_W+1:0]   n_rem;
    logic [N_W+1:0]   n_trial;
    logic [WP_W-1:0]  mag;
    logic             over;

    assign mag = i_req.num[WP_W-1] ? WP_W'(-i_req.num) : WP_W'(i_req.num);

    always_comb begin
        n_rem   = {r_rem[N_W:0], r_num[N_W+1]};
        n_trial = n_rem - (N_W+2)'(r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(N_W + 2);
                r_rem  <= '0;
                r_num  <= (N_W+2)'({mag, 1'b0}) + (N_W+2)'(i_req.den);
                r_den  <= D_W'({i_req.den, 1'b0});
                r_q    <= '0;
                r_neg  <= i_req.num[WP_W-1];
            end else if (r_busy) begin
                r_num <= {r_num[N_W:0], 1'b0};
                if (!n_trial[N_W+1]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[Q_W-2:0], 1'b1} | {Q_W{r_q[Q_W-1]}};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[Q_W-2:0], 1'b0} | {Q_W{r_q[Q_W-1]}};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient register sticks at all ones once it overflows.
    always_comb begin
        if (r_neg) begin
            over   = r_q > Q_W'(32768);
            o_quot = over ? 16'sh8000 : P_W'(-$signed({1'b0, r_q}));
        end else begin
            over   = r_q > Q_W'(32767);
            o_quot = over ? 16'sd32767 : P_W'(r_q);
        end
    end
    assign o_done = r_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("divider done while busy");
endmodule

// File: src/ccs_store.sv
// Hit loading and peak tracking, a window-sum pass, centroid division and output.
module ccs_store
    import ccs_pkg::*;
#(
    parameter int unsigned MAX_HITS  = 64,
    parameter int unsigned GRID_SIDE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ccs_if.sink                  i_hit,
    input  logic                 i_res_free,
    output logic                 o_res_valid,
    output t_result              o_res,
    output t_div_req             o_div,
    input  logic                 i_div_done,
    input  logic signed [P_W-1:0] i_div_q
);
    localparam int unsigned AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int unsigned CW = $clog2(MAX_HITS + 1);
    localparam int unsigned GW = $clog2(GRID_SIDE) + 2;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_PEAK  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DIVX  = 6'b001000,
        S_DIVY  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_hit               mem [MAX_HITS];
    t_hit               r_rd;
    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_peak_idx;
    logic signed [E_W-1:0] r_peak_e;
    logic [CW-1:0]      r_i;
    logic               r_rd_v;
    logic [2:0]         r_pc, r_pr;
    logic [ACC_W-1:0]   r_c, r_x, r_t, r_f, r_all;
    logic signed [WP_W-1:0] r_wx, r_wy;
    logic [24:0]        r_o5, r_o3, r_ox;
    logic               r_div_wait;
    logic signed [P_W-1:0] r_cx;
    logic signed [P_W-1:0] r_cy;
    t_result            r_res;
    logic               r_res_valid;

    logic               take;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic signed [3:0]  dxs, dys;
    logic [2:0]         dx, dy;
    logic [E_W-1:0]     e_pos;
    logic [4:0]         bit_i;
    logic [24:0]        bmask;
    logic               in5, in3, inx, inc;
    logic signed [WP_W-1:0] px_e, py_e;
    logic [4:0]         n5;
    logic [3:0]         n3;
    logic [2:0]         nx;
    logic signed [GW-1:0] dcol, drow;
    logic [GW-1:0]      dmax;
    logic [1:0]         ring;
    logic               good;

    assign i_hit.ready = (r_state == S_LOAD);
    assign take        = i_hit.valid && i_hit.ready;

    always_ff @(posedge i_clk) begin
        if (take && r_cnt < CW'(MAX_HITS))
            mem[r_cnt[AW-1:0]] <= '{i_hit.data.col, i_hit.data.row, i_hit.data.energy,
                                     i_hit.data.pos_x, i_hit.data.pos_y};
        if (rd_en)
            r_rd <= mem[rd_addr];
    end

    always_comb begin
        rd_en   = (r_state == S_PEAK) || (r_state == S_SCAN && r_i < r_cnt);
        rd_addr = (r_state == S_PEAK) ? r_peak_idx : r_i[AW-1:0];
    end

    // Window geometry of the word just read against the peak position.
    always_comb begin
        dxs   = $signed({1'b0, r_pc}) - $signed({1'b0, r_rd.col});
        dys   = $signed({1'b0, r_pr}) - $signed({1'b0, r_rd.row});
        dx    = dxs[3] ? 3'(-dxs) : dxs[2:0];
        dy    = dys[3] ? 3'(-dys) : dys[2:0];
        e_pos = r_rd.energy[E_W-1] ? '0 : r_rd.energy;
        in5   = dx < 3'd3 && dy < 3'd3;
        in3   = dx < 3'd2 && dy < 3'd2;
        inx   = in3 && (4'(dx) + 4'(dy) < 4'd2);
        inc   = dx == 3'd0 && dy == 3'd0;
        bit_i = 5'((4'(dxs) + 4'sd2) * 5 + (4'(dys) + 4'sd2));
        bmask = in5 ? (25'd1 << bit_i) : '0;
        px_e  = WP_W'(r_rd.pos_x) * $signed({1'b0, e_pos});
        py_e  = WP_W'(r_rd.pos_y) * $signed({1'b0, e_pos});
    end

    always_comb begin
        n5 = '0; n3 = '0; nx = '0;
        for (int k = 0; k < 25; k++) begin
            n5 = n5 + 5'(r_o5[k]);
            n3 = n3 + 4'(r_o3[k]);
            nx = nx + 3'(r_ox[k]);
        end
        dcol = $signed(GW'({r_pc, 1'b0})) - $signed(GW'(GRID_SIDE - 1));
        drow = $signed(GW'({r_pr, 1'b0})) - $signed(GW'(GRID_SIDE - 1));
        dcol = dcol[GW-1] ? -dcol : dcol;
        drow = drow[GW-1] ? -drow : drow;
        dmax = ($unsigned(dcol) > $unsigned(drow)) ? $unsigned(dcol) : $unsigned(drow);
        ring = (dmax[GW-1:1] > (GW-1)'(3)) ? 2'd3 : dmax[2:1];
        good = r_c != '0;
    end

    always_comb begin
        o_div.start = 1'b0;
        o_div.num   = r_wx;
        o_div.den   = r_f;
        if (r_state == S_DIVX && !r_div_wait) o_div.start = 1'b1;
        if (r_state == S_DIVY) begin
            o_div.num = r_wy;
            o_div.start = !r_div_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_peak_idx  <= '0;
            r_peak_e    <= {1'b1, {(E_W-1){1'b0}}};
            r_res_valid <= 1'b0;
            r_div_wait  <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            if (i_res_free && r_state != S_OUT) r_res_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (take) begin
                        if (r_cnt < CW'(MAX_HITS)) begin
                            if (i_hit.data.energy > r_peak_e) begin
                                r_peak_e   <= i_hit.data.energy;
                                r_peak_idx <= r_cnt[AW-1:0];
                            end
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (i_hit.data.last_hit) r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    r_i <= '0;
                    r_rd_v <= 1'b0;
                    r_c <= '0; r_x <= '0; r_t <= '0; r_f <= '0; r_all <= '0;
                    r_wx <= '0; r_wy <= '0; r_o5 <= '0; r_o3 <= '0; r_ox <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // first cycle latches the peak position from the read word
                    if (!r_rd_v) begin
                        r_pc   <= r_rd.col;
                        r_pr   <= r_rd.row;
                        r_rd_v <= 1'b1;
                        r_i    <= CW'(1);
                    end else begin
                        r_all <= r_all + ACC_W'(e_pos);
                        if (in5) begin
                            r_f  <= r_f + ACC_W'(e_pos);
                            r_wx <= r_wx + px_e;
                            r_wy <= r_wy + py_e;
                            r_o5 <= r_o5 | bmask;
                        end
                        if (in3) begin
                            r_t  <= r_t + ACC_W'(e_pos);
                            r_o3 <= r_o3 | bmask;
                        end
                        if (inx) begin
                            r_x  <= r_x + ACC_W'(e_pos);
                            r_ox <= r_ox | bmask;
                        end
                        if (inc) r_c <= r_c + ACC_W'(e_pos);
                        // the word read holds entry r_i-1
                        if (r_i == r_cnt) r_state <= S_DIVX;
                        else r_i <= r_i + CW'(1);
                    end
                end
                S_DIVX: begin
                    r_rd_v <= 1'b0;
                    if (!good || r_f == '0) begin
                        r_state <= S_OUT;
                    end else if (!r_div_wait) begin
                        r_div_wait <= 1'b1;
                    end else if (i_div_done) begin
                        r_cx <= i_div_q;
                        r_div_wait <= 1'b0;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (!r_div_wait) r_div_wait <= 1'b1;
                    else if (i_div_done) begin
                        r_div_wait <= 1'b0;
                        r_cy       <= i_div_q;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_res_valid || i_res_free) begin
                        if (!good || r_f == '0) begin
                            r_res.centroid_x <= '0;
                            r_res.centroid_y <= '0;
                            r_res.ring_index <= '0;
                        end else begin
                            r_res.centroid_x <= r_cx;
                            r_res.centroid_y <= r_cy;
                            r_res.ring_index <= ring;
                        end
                        r_res.good           <= good;
                        r_res.sum_center     <= sat29(r_c);
                        r_res.sum_cross      <= sat29(r_x);
                        r_res.sum_three      <= sat29(r_t);
                        r_res.sum_five       <= sat29(r_f);
                        r_res.sum_total      <= sat29(r_all);
                        r_res.occupied_cross <= nx;
                        r_res.occupied_three <= n3;
                        r_res.occupied_five  <= n5;
                        r_res_valid <= 1'b1;
                        r_cnt      <= '0;
                        r_peak_idx <= '0;
                        r_peak_e   <= {1'b1, {(E_W-1){1'b0}}};
                        r_state    <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(MAX_HITS))
        else $error("hit count beyond store depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && (!r_res_valid || i_res_free) |=> r_state == S_LOAD && r_res_valid)
        else $error("result not issued on leaving output state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD && r_state != S_PEAK) |-> r_cnt != '0)
        else $error("second pass on an empty event");
endmodule

// File: src/calorimeter_cluster_sums.sv
// Top level of the calorimeter cluster sum block.
//  channel  | dir | payload
//  i_hit    | in  | t_in: col, row, energy, pos_x, pos_y, last_hit
//  o_res    | out | t_result: sums, centroid, ring, occupancies
// Flow: a hit is taken whenever offered while loading; at the event end a peak read,
// a memory pass over N stored hits, then two divider runs for the centroid
// (skipped when the peak crystal holds no energy) and an output step.
// Reset: synchronous, active low; event state cleared, hit memory left as is.
// Stalls: a held result blocks the next event only at its own output step.
module calorimeter_cluster_sums
    import ccs_pkg::*;
#(
    parameter int unsigned MAX_HITS  = 64,
    parameter int unsigned GRID_SIDE = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ccs_if.sink    i_hit,
    ccs_if.source  o_res
);
    t_div_req              div_req;
    logic                  div_done;
    logic signed [P_W-1:0] div_q;
    logic                  res_valid;
    t_result               res;
    logic                  res_free;

    assign res_free    = o_res.ready;
    assign o_res.valid = res_valid;
    assign o_res.data  = res;

    ccs_store #(.MAX_HITS(MAX_HITS), .GRID_SIDE(GRID_SIDE)) u_store (
        .i_clk, .i_rst_n, .i_hit,
        .i_res_free(res_free), .o_res_valid(res_valid), .o_res(res),
        .o_div(div_req), .i_div_done(div_done), .i_div_q(div_q)
    );

    ccs_div u_div (
        .i_clk, .i_rst_n, .i_req(div_req), .o_done(div_done), .o_quot(div_q)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid)
        else $error("result dropped while stalled");
endmodule
